// ----- design/bmic_pkg.sv -----
package bmic_pkg;

	// Item kinds carried on the input tuser.
	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_PRG   = 2'd2;
	localparam logic [1:0] FUNC_CHR   = 2'd3;

	// Register pages seen through the 0xF003 write decode.
	localparam logic [3:0] PAGE_PRG_LO  = 4'h8;
	localparam logic [3:0] PAGE_PRG_HI  = 4'h9;
	localparam logic [3:0] PAGE_CHR_FST = 4'hA;
	localparam logic [3:0] PAGE_CHR_LST = 4'hD;
	localparam logic [3:0] PAGE_RELOAD  = 4'hE;
	localparam logic [3:0] PAGE_IRQ     = 4'hF;

	localparam logic [1:0] REG_WRAM_EN   = 2'd2;
	localparam logic [1:0] REG_IRQ_RELD  = 2'd0;
	localparam logic [1:0] REG_IRQ_CTRL  = 2'd1;
	localparam logic [1:0] REG_MIRROR    = 2'd2;

	localparam logic [2:0] WRAM_WINDOW   = 3'b011;
	localparam logic [1:0] PRG_FIXED_SLOT = 2'd3;

	localparam logic [15:0] MASK_4  = 16'h000F;
	localparam logic [15:0] MASK_8  = 16'h00FF;
	localparam logic [15:0] MASK_12 = 16'h0FFF;
	localparam logic [15:0] MASK_16 = 16'hFFFF;

	localparam logic [5:0] LAST_PRG_RESET = 6'd63;
	localparam logic [1:0] MIRROR_HORIZONTAL = 2'd0;

	typedef struct packed {
		logic        tick;
		logic        reload;
		logic        ctrl;
		logic        enable;
		logic [15:0] mask;
		logic [15:0] reload_val;
	} irq_cmd_t;

	// Packed so that irq_out sits in the lowest bit.
	typedef struct packed {
		logic [1:0] mirroring;
		logic       ram_write;
		logic [7:0] bank;
		logic       irq_out;
	} res_t;

endpackage

// ----- design/bmic_irq.sv -----
module bmic_irq (
	input  logic                clk,
	input  logic                arst_n,
	input  bmic_pkg::irq_cmd_t  cmd,
	output logic                irq_next
);

	logic [15:0] count_q;
	logic [15:0] mask_q;
	logic        enable_q;
	logic        ack_q;
	logic        level_q;

	logic [15:0] count_d;
	logic [15:0] mask_d;
	logic        enable_d;
	logic        ack_d;
	logic        level_d;
	logic [15:0] dec;

	assign dec = (count_q & mask_q) - 16'd1;

	always_comb begin
		count_d  = count_q;
		mask_d   = mask_q;
		enable_d = enable_q;
		ack_d    = ack_q;
		level_d  = level_q;
		if (cmd.tick) begin
			ack_d = 1'b0;
			if (ack_q) begin
				level_d = 1'b0;
			end
			if (enable_q) begin
				// Only a masked count stepping from one to zero raises the line.
				if (dec == 16'd0) begin
					level_d = 1'b1;
				end
				count_d = (count_q & ~mask_q) | (dec & mask_q);
			end
		end
		if (cmd.reload) begin
			ack_d   = 1'b1;
			count_d = cmd.reload_val;
		end
		if (cmd.ctrl) begin
			ack_d    = 1'b1;
			enable_d = cmd.enable;
			mask_d   = cmd.mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mask_q   <= '0;
			enable_q <= 1'b0;
			ack_q    <= 1'b0;
			level_q  <= 1'b0;
		end else begin
			count_q  <= count_d;
			mask_q   <= mask_d;
			enable_q <= enable_d;
			ack_q    <= ack_d;
			level_q  <= level_d;
		end
	end

	assign irq_next = level_d;

`ifndef SYNTHESIS
	// An acknowledge with counting off always clears the line on the next tick.
	a_ack_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick && ack_q && !enable_q |=> !level_q)
		else $error("acknowledged IRQ not dropped on tick");
	// The line only changes on a tick.
	a_level_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.tick |=> $stable(level_q))
		else $error("IRQ level changed without a tick");
`endif

endmodule

// ----- design/bmic_core.sv -----
module bmic_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [1:0]        func,
	input  logic [15:0]       addr,
	input  logic [7:0]        wdata,
	input  logic [5:0]        last_prg_bank,
	output bmic_pkg::res_t    res
);

	logic [5:0] prg_bank_q [3];
	logic [7:0] chr_bank_q [8];
	logic [3:0] reload_q [4];
	logic       wram_q;
	logic [1:0] mirror_q;

	logic [3:0] page;
	logic [1:0] low;
	logic       is_write;
	logic       wr_prg;
	logic [1:0] prg_slot_w;
	logic       wr_wram;
	logic       wr_chr;
	logic [3:0] chr_idx;
	logic       wr_reload;
	logic       wr_mirror;
	logic [15:0] mask_sel;
	logic [1:0] prg_slot_r;
	logic [7:0] bank;
	logic       irq_next;
	bmic_pkg::irq_cmd_t cmd;

	assign page     = addr[15:12];
	assign low      = addr[1:0];
	assign is_write = fire && (func == bmic_pkg::FUNC_WRITE);

	always_comb begin
		wr_prg     = 1'b0;
		prg_slot_w = {1'b0, low[1]};
		if (page == bmic_pkg::PAGE_PRG_LO) begin
			wr_prg = is_write;
		end else if (page == bmic_pkg::PAGE_PRG_HI && !low[1]) begin
			wr_prg     = is_write;
			prg_slot_w = 2'd2;
		end
	end

	assign wr_wram   = is_write && page == bmic_pkg::PAGE_PRG_HI
		&& low == bmic_pkg::REG_WRAM_EN;
	assign wr_chr    = is_write && page >= bmic_pkg::PAGE_CHR_FST
		&& page <= bmic_pkg::PAGE_CHR_LST;
	assign chr_idx   = {page[1:0] - bmic_pkg::PAGE_CHR_FST[1:0], low};
	assign wr_reload = is_write && page == bmic_pkg::PAGE_RELOAD;
	assign wr_mirror = is_write && page == bmic_pkg::PAGE_IRQ
		&& low == bmic_pkg::REG_MIRROR;

	always_comb begin
		if (wdata[3]) begin
			mask_sel = bmic_pkg::MASK_4;
		end else if (wdata[2]) begin
			mask_sel = bmic_pkg::MASK_8;
		end else if (wdata[1]) begin
			mask_sel = bmic_pkg::MASK_12;
		end else begin
			mask_sel = bmic_pkg::MASK_16;
		end
	end

	always_comb begin
		cmd.tick   = fire && (func == bmic_pkg::FUNC_TICK);
		cmd.reload = is_write && page == bmic_pkg::PAGE_IRQ
			&& low == bmic_pkg::REG_IRQ_RELD;
		cmd.ctrl   = is_write && page == bmic_pkg::PAGE_IRQ
			&& low == bmic_pkg::REG_IRQ_CTRL;
		cmd.enable = wdata[0];
		cmd.mask   = mask_sel;
		cmd.reload_val = {reload_q[3], reload_q[2], reload_q[1], reload_q[0]};
	end

	bmic_irq u_irq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.irq_next  (irq_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				prg_bank_q[i] <= '0;
			end
			for (int i = 0; i < 8; i++) begin
				chr_bank_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				reload_q[i] <= '0;
			end
			wram_q   <= 1'b1;
			mirror_q <= bmic_pkg::MIRROR_HORIZONTAL;
		end else begin
			if (wr_prg) begin
				if (low[0]) begin
					prg_bank_q[prg_slot_w][5:4] <= wdata[1:0];
				end else begin
					prg_bank_q[prg_slot_w][3:0] <= wdata[3:0];
				end
			end
			if (wr_chr) begin
				if (chr_idx[0]) begin
					chr_bank_q[chr_idx[3:1]][7:4] <= wdata[3:0];
				end else begin
					chr_bank_q[chr_idx[3:1]][3:0] <= wdata[3:0];
				end
			end
			if (wr_reload) begin
				reload_q[low] <= wdata[3:0];
			end
			if (wr_wram) begin
				wram_q <= (wdata[1:0] != 2'b00);
			end
			if (wr_mirror) begin
				mirror_q <= wdata[1:0];
			end
		end
	end

	assign prg_slot_r = addr[14:13];

	always_comb begin
		bank = '0;
		case (func)
			bmic_pkg::FUNC_PRG: begin
				if (addr[15]) begin
					if (prg_slot_r == bmic_pkg::PRG_FIXED_SLOT) begin
						bank = {2'b00, last_prg_bank};
					end else begin
						bank = {2'b00, prg_bank_q[prg_slot_r]};
					end
				end
			end
			bmic_pkg::FUNC_CHR: begin
				if (addr[15:13] == 3'b000) begin
					bank = chr_bank_q[addr[12:10]];
				end
			end
			default: begin
				bank = '0;
			end
		endcase
	end

	always_comb begin
		res.irq_out   = irq_next;
		res.bank      = bank;
		res.ram_write = (func == bmic_pkg::FUNC_WRITE) && wram_q
			&& addr[15:13] == bmic_pkg::WRAM_WINDOW;
		res.mirroring = wr_mirror ? wdata[1:0] : mirror_q;
	end

endmodule

// ----- design/bank_mapper_with_irq_counter_top.sv -----
// Cartridge bank mapper with a CPU cycle IRQ counter. Each request on the input stream is a CPU
// write, a CPU cycle tick or a PRG/CHR address lookup, selected by s_tuser, and each request
// yields exactly one result: the IRQ line level after the request, the looked-up bank (zero for
// writes and ticks), a work RAM write strobe and the current mirroring mode. A request is
// evaluated while it sits in the input register and is loaded into the result register as it
// advances, once the result register is empty or being read; a new request is taken every cycle
// while the result side keeps up. The register that holds the fixed top PRG bank is written
// through the cfg port; the user must do this only while the block is idle; it is not enforced.
module bank_mapper_with_irq_counter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // addr[15:0], wdata[23:16]
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // irq_out[0], bank[8:1], ram_write[9], mirroring[11:10]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data   // last_prg_bank
);

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	logic        m_tvalid_q;
	bmic_pkg::res_t res_q;
	bmic_pkg::res_t res;
	logic [5:0]  last_prg_q;
	logic        advance;

	assign advance   = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_prg_q <= bmic_pkg::LAST_PRG_RESET;
		end else if (cfg_valid) begin
			last_prg_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= s_tuser;
			addr_s1  <= s_tdata[15:0];
			wdata_s1 <= s_tdata[23:16];
		end
	end

	bmic_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (advance),
		.func          (func_s1),
		.addr          (addr_s1),
		.wdata         (wdata_s1),
		.last_prg_bank (last_prg_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0000, res_q};

`ifndef SYNTHESIS
	// A request held in the input register is never dropped while the output stalls.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid_q && !m_tready |=> valid_s1 && $stable(addr_s1))
		else $error("input stage lost a request under back-pressure");
	// Every request that leaves the input register becomes a pending result.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid_q)
		else $error("advanced request produced no result");
	// Ticks and lookups never strobe the work RAM.
	a_no_ramw: assert property (@(posedge clk) disable iff (!arst_n)
		advance && func_s1 != bmic_pkg::FUNC_WRITE |=> !res_q.ram_write)
		else $error("work RAM strobe on a non-write request");
	// Writes and ticks carry a zero bank.
	a_bank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (func_s1 == bmic_pkg::FUNC_WRITE || func_s1 == bmic_pkg::FUNC_TICK)
		|=> res_q.bank == 8'd0)
		else $error("nonzero bank on a write or tick");
`endif

endmodule
